// ===== hdl/dpc1d_pkg.sv =====
// Package: constants, item types and control structs for the dilated 1-D convolution block
`timescale 1ns / 1ps
package dpc1d_pkg;

  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_TAPS   = 8;
  localparam int MAX_IN_LEN = 256;

  localparam int CH_W     = 4;
  localparam int TAP_W    = 3;
  localparam int POS_W    = 9;
  localparam int SAMPLE_W = 16;
  localparam int BIAS_W   = 32;
  localparam int RES_W    = 40;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = RES_W + 1;

  localparam int NCH_W   = 5;
  localparam int NTAP_W  = 4;
  localparam int LEN_W   = 9;
  localparam int PAD_W   = 7;
  localparam int DIL_W   = 7;
  localparam int OLEN_W  = 11;
  localparam int TI_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int OC_AW  = $clog2(MAX_OUT_CH);
  localparam int IC_AW  = $clog2(MAX_IN_CH);
  localparam int TAP_AW = $clog2(MAX_TAPS);
  localparam int LEN_AW = $clog2(MAX_IN_LEN);
  localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
  localparam int S_DEPTH = MAX_IN_CH * MAX_IN_LEN;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_TAPS    = 3'd2,
    REG_IN_LEN  = 3'd3,
    REG_PAD     = 3'd4,
    REG_DIL     = 3'd5,
    REG_BIAS_EN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    mode_e                      mode;
    logic [CH_W-1:0]            out_channel;
    logic [CH_W-1:0]            in_channel;
    logic [TAP_W-1:0]           tap;
    logic [POS_W-1:0]           position;
    logic signed [SAMPLE_W-1:0] sample_or_weight;
    logic signed [BIAS_W-1:0]   bias_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         result_channel;
    logic [POS_W-1:0]        result_time;
    logic signed [RES_W-1:0] result_value;
    logic                    saturated;
    logic                    status;
  } out_item_t;

  typedef struct packed {
    logic [NCH_W-1:0]         n_in_ch;
    logic [NCH_W-1:0]         n_out_ch;
    logic [NTAP_W-1:0]        n_taps;
    logic [LEN_W-1:0]         n_len;
    logic [PAD_W-1:0]         pad;
    logic [DIL_W-1:0]         dil;
    logic                     bias_en;
    logic signed [OLEN_W-1:0] out_len;
  } cfg_t;

  typedef struct packed {
    logic              take;
    logic              start;
    logic              issue;
    logic              last_tap;
    logic [CH_W-1:0]   chan;
    logic [TAP_W-1:0]  tap;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic query_bad;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/dpc1d_cfg.sv =====
// Configuration registers with range clamping and output length
`timescale 1ns / 1ps
module dpc1d_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpc1d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpc1d_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output dpc1d_pkg::cfg_t                    cfg_o
);
  import dpc1d_pkg::*;

  logic [NCH_W-1:0]  in_ch_q, out_ch_q;
  logic [NTAP_W-1:0] taps_q;
  logic [LEN_W-1:0]  len_q;
  logic [PAD_W-1:0]  pad_q;
  logic [DIL_W-1:0]  dil_q;
  logic              bias_en_q;

  logic [9:0] span;
  logic [9:0] reach;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q   <= NCH_W'(1);
      out_ch_q  <= NCH_W'(1);
      taps_q    <= NTAP_W'(1);
      len_q     <= LEN_W'(1);
      pad_q     <= '0;
      dil_q     <= DIL_W'(1);
      bias_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_IN_CH:   in_ch_q   <= cfg_data_i[NCH_W-1:0];
        REG_OUT_CH:  out_ch_q  <= cfg_data_i[NCH_W-1:0];
        REG_TAPS:    taps_q    <= cfg_data_i[NTAP_W-1:0];
        REG_IN_LEN:  len_q     <= cfg_data_i[LEN_W-1:0];
        REG_PAD:     pad_q     <= cfg_data_i[PAD_W-1:0];
        REG_DIL:     dil_q     <= cfg_data_i[DIL_W-1:0];
        REG_BIAS_EN: bias_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o = '0;
    cfg_o.n_in_ch  = (in_ch_q == '0) ? NCH_W'(1) :
                     (in_ch_q > NCH_W'(MAX_IN_CH)) ? NCH_W'(MAX_IN_CH) : in_ch_q;
    cfg_o.n_out_ch = (out_ch_q == '0) ? NCH_W'(1) :
                     (out_ch_q > NCH_W'(MAX_OUT_CH)) ? NCH_W'(MAX_OUT_CH) : out_ch_q;
    cfg_o.n_taps   = (taps_q == '0) ? NTAP_W'(1) :
                     (taps_q > NTAP_W'(MAX_TAPS)) ? NTAP_W'(MAX_TAPS) : taps_q;
    cfg_o.n_len    = (len_q == '0) ? LEN_W'(1) :
                     (len_q > LEN_W'(MAX_IN_LEN)) ? LEN_W'(MAX_IN_LEN) : len_q;
    cfg_o.pad      = pad_q;
    cfg_o.dil      = (dil_q == '0) ? DIL_W'(1) : dil_q;
    cfg_o.bias_en  = bias_en_q;
    span  = 10'(cfg_o.dil) * 10'(cfg_o.n_taps - NTAP_W'(1));
    reach = 10'(cfg_o.n_len) + {2'b00, pad_q, 1'b0};
    cfg_o.out_len  = $signed({1'b0, reach}) - $signed({1'b0, span});
  end

endmodule

// ===== hdl/dpc1d_ctrl.sv =====
// Controller: item intake, channel/tap sequencing, pipeline drain and result handoff
`timescale 1ns / 1ps
module dpc1d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  dpc1d_pkg::mode_e    mode_i,
  input  dpc1d_pkg::cfg_t     cfg_i,
  input  dpc1d_pkg::stat_t    stat_i,
  output logic                in_stall_o,
  output dpc1d_pkg::cmd_t     cmd_o
);
  import dpc1d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // memory read and multiply stages between the last issue and a settled sum
  localparam int DRAIN_CYCLES = 2;
  localparam int DRN_W = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

  state_e            state_q;
  logic [CH_W-1:0]   c_q;
  logic [TAP_W-1:0]  k_q;
  logic [DRN_W-1:0]  drain_q;
  logic              last_chan;

  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.start    = cmd_o.take && (mode_i == MODE_QUERY);
    cmd_o.issue    = (state_q == ST_RUN);
    cmd_o.last_tap = ({1'b0, k_q} == (cfg_i.n_taps - NTAP_W'(1)));
    cmd_o.chan     = c_q;
    cmd_o.tap      = k_q;
    cmd_o.finish   = (state_q == ST_DONE) && !stat_i.out_busy;
    last_chan      = ({1'b0, c_q} == (cfg_i.n_in_ch - NCH_W'(1)));
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      c_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            c_q     <= '0;
            k_q     <= '0;
            state_q <= stat_i.query_bad ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_o.last_tap) begin
            k_q <= '0;
            if (last_chan) begin
              drain_q <= DRN_W'(DRAIN_CYCLES - 1);
              state_q <= ST_DRAIN;
            end else begin
              c_q <= c_q + CH_W'(1);
            end
          end else begin
            k_q <= k_q + TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            drain_q <= drain_q - DRN_W'(1);
          end
        end
        ST_DONE: begin
          if (!stat_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/dpc1d_dp.sv =====
// Datapath: weight/sample/bias stores, tap index walk, shared MAC, saturation and output register
`timescale 1ns / 1ps
module dpc1d_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dpc1d_pkg::in_item_t   in_item_i,
  input  dpc1d_pkg::cfg_t       cfg_i,
  input  dpc1d_pkg::cmd_t       cmd_i,
  input  logic                  out_stall_i,
  output dpc1d_pkg::stat_t      stat_o,
  output logic                  out_valid_o,
  output dpc1d_pkg::out_item_t  out_item_o
);
  import dpc1d_pkg::*;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  logic signed [SAMPLE_W-1:0] w_mem [W_DEPTH];
  logic signed [SAMPLE_W-1:0] s_mem [S_DEPTH];
  logic signed [BIAS_W-1:0]   bias_q [MAX_OUT_CH];

  logic [CH_W-1:0]            q_oc_q;
  logic [POS_W-1:0]           q_pos_q;
  logic                       bad_q;
  logic signed [TI_W-1:0]     base_q, ti_q, base_d;
  logic signed [SAMPLE_W-1:0] w_rd_q, s_rd_q;
  logic                       rd_v_q, prod_v_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, sum_d, bias_ext;
  logic                       ti_ok;
  logic                       out_valid_q;
  out_item_t                  out_q;

  assign base_d = $signed({(TI_W-POS_W)'(0), in_item_i.position})
                - $signed({(TI_W-PAD_W)'(0), cfg_i.pad});
  assign ti_ok  = !ti_q[TI_W-1] && (ti_q[TI_W-2:0] < (TI_W-1)'(cfg_i.n_len));

  assign stat_o.query_bad =
      ({1'b0, in_item_i.out_channel} >= cfg_i.n_out_ch) ||
      ($signed({(OLEN_W-POS_W)'(0), in_item_i.position}) >= cfg_i.out_len);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  // stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_item_i.mode == MODE_WEIGHT) begin
      w_mem[{in_item_i.out_channel, in_item_i.in_channel, in_item_i.tap}]
        <= in_item_i.sample_or_weight;
    end
    if (cmd_i.issue) begin
      w_rd_q <= w_mem[{q_oc_q, cmd_i.chan, cmd_i.tap}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_item_i.mode == MODE_SAMPLE &&
        in_item_i.position < cfg_i.n_len) begin
      s_mem[{in_item_i.in_channel, in_item_i.position[LEN_AW-1:0]}]
        <= in_item_i.sample_or_weight;
    end
    if (cmd_i.issue) begin
      s_rd_q <= s_mem[{cmd_i.chan, ti_q[LEN_AW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_item_i.mode == MODE_BIAS) begin
      bias_q[in_item_i.out_channel] <= in_item_i.bias_value;
    end
  end

  // query context and input time walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_oc_q  <= in_item_i.out_channel;
      q_pos_q <= in_item_i.position;
      bad_q   <= stat_o.query_bad;
      base_q  <= base_d;
      ti_q    <= base_d;
    end else if (cmd_i.issue) begin
      ti_q <= cmd_i.last_tap ? base_q : ti_q + $signed({(TI_W-DIL_W)'(0), cfg_i.dil});
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= s_rd_q * w_rd_q;
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue && ti_ok;
      prod_v_q <= rd_v_q;
    end
  end

  // bias, saturation, result register
  assign bias_ext = cfg_i.bias_en ?
                    {{(ACC_W-BIAS_W){bias_q[q_oc_q][BIAS_W-1]}}, bias_q[q_oc_q]} : '0;
  assign sum_d    = acc_q + bias_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.result_channel <= q_oc_q;
      out_q.result_time    <= q_pos_q;
      out_q.status         <= bad_q;
      if (bad_q) begin
        out_q.result_value <= '0;
        out_q.saturated    <= 1'b0;
      end else if (sum_d[ACC_W-1] != sum_d[ACC_W-2]) begin
        out_q.result_value <= sum_d[ACC_W-1] ? RES_MIN : RES_MAX;
        out_q.saturated    <= 1'b1;
      end else begin
        out_q.result_value <= sum_d[RES_W-1:0];
        out_q.saturated    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/dilated_padded_conv1d_top.sv =====
// Top level: dilated zero-padded 1-D convolution, config registers, controller and datapath
// Timing: a store item is written at intake; a query walks every input channel and kernel tap
//   with one MAC per cycle, then passes the read, multiply and bias/saturate stages; a query
//   that is out of range skips the walk and goes straight to the result register.
// Throughput: intake stalls until the result is loaded, so a new query is taken only after the
//   previous one is through, later while a previous result is held by output stall.
`timescale 1ns / 1ps
module dilated_padded_conv1d_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpc1d_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dpc1d_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dpc1d_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dpc1d_pkg::out_item_t              out_item_o
);
  import dpc1d_pkg::*;

  // Async active-low reset clears control and sets config defaults; stores stay undefined.
  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  dpc1d_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dpc1d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_item_i.mode),
    .cfg_i      (cfg),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  dpc1d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  a_finish_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while held");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished query produced no valid item");

  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> in_stall_o)
    else $error("intake not stalled after query start");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |-> (!out_item_o.saturated &&
                                            out_item_o.result_value == '0))
    else $error("error status item carries a value");
`endif

endmodule

// ===== bench/conv_checker.sv =====
// Checker for the dilated 1-D convolution block: mirrors its stores and registers, predicts outputs
`timescale 1ns / 1ps
module conv_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpc1d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpc1d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  dpc1d_pkg::in_item_t              in_item_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  dpc1d_pkg::out_item_t             out_item_i,
  output int                               mismatch_o,
  output int                               pending_o
);
  import dpc1d_pkg::*;

  localparam longint SUM_MAX = (longint'(1) <<< (RES_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (RES_W - 1));

  logic [NCH_W-1:0]  in_ch_q;
  logic [NCH_W-1:0]  out_ch_q;
  logic [NTAP_W-1:0] taps_q;
  logic [LEN_W-1:0]  len_q;
  logic [PAD_W-1:0]  pad_q;
  logic [DIL_W-1:0]  dil_q;
  logic              bias_en_q;

  logic signed [SAMPLE_W-1:0] wt_mem   [W_DEPTH];
  logic signed [SAMPLE_W-1:0] smp_mem  [S_DEPTH];
  logic signed [BIAS_W-1:0]   bias_mem [MAX_OUT_CH];

  out_item_t due_outputs [$];

  function automatic int clamp_count(input int raw, input int maxv);
    if (raw < 1) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic int eff_len();
    return clamp_count(int'(len_q), MAX_IN_LEN);
  endfunction

  function automatic out_item_t conv_point(input logic [CH_W-1:0] oc,
                                           input logic [POS_W-1:0] pos);
    out_item_t r;
    int        nic, noc, nk, nlen, dil, olen, ti, c, k;
    longint    acc;
    nic  = clamp_count(int'(in_ch_q), MAX_IN_CH);
    noc  = clamp_count(int'(out_ch_q), MAX_OUT_CH);
    nk   = clamp_count(int'(taps_q), MAX_TAPS);
    nlen = eff_len();
    dil  = (dil_q == '0) ? 1 : int'(dil_q);
    olen = nlen + 2 * int'(pad_q) - dil * (nk - 1);
    acc  = 0;
    r.result_channel = oc;
    r.result_time    = pos;
    r.saturated      = 1'b0;
    r.status         = 1'b0;
    if (int'(oc) >= noc || int'(pos) >= olen) begin
      r.status = 1'b1;
    end else begin
      for (c = 0; c < nic; c++) begin
        for (k = 0; k < nk; k++) begin
          ti = int'(pos) + k * dil - int'(pad_q);
          if (ti >= 0 && ti < nlen)
            acc += longint'(smp_mem[c * MAX_IN_LEN + ti])
                 * longint'(wt_mem[(int'(oc) * MAX_IN_CH + c) * MAX_TAPS + k]);
        end
      end
      if (bias_en_q) acc += longint'(bias_mem[oc]);
      if (acc > SUM_MAX) begin
        acc = SUM_MAX;
        r.saturated = 1'b1;
      end
      if (acc < SUM_MIN) begin
        acc = SUM_MIN;
        r.saturated = 1'b1;
      end
    end
    r.result_value = acc[RES_W-1:0];
    return r;
  endfunction

  task automatic check_output(input out_item_t got);
    out_item_t want;
    if (due_outputs.size() == 0) begin
      mismatch_o++;
      if (mismatch_o <= 10)
        $display("conv check: output ch=%0d t=%0d value=%0d with nothing pending",
                 got.result_channel, got.result_time, got.result_value);
    end else begin
      want = due_outputs.pop_front();
      if (got.result_channel !== want.result_channel || got.result_time !== want.result_time ||
          got.result_value !== want.result_value || got.saturated !== want.saturated ||
          got.status !== want.status) begin
        mismatch_o++;
        if (mismatch_o <= 10)
          $display("conv check: exp %0d/%0d %0d sat %b st %b, got %0d/%0d %0d sat %b st %b",
                   want.result_channel, want.result_time, want.result_value, want.saturated,
                   want.status, got.result_channel, got.result_time, got.result_value,
                   got.saturated, got.status);
      end
    end
  endtask

  task automatic apply_item(input in_item_t it);
    case (it.mode)
      MODE_WEIGHT:
        wt_mem[(int'(it.out_channel) * MAX_IN_CH + int'(it.in_channel)) * MAX_TAPS
               + int'(it.tap)] = it.sample_or_weight;
      MODE_BIAS:
        bias_mem[it.out_channel] = it.bias_value;
      MODE_SAMPLE:
        if (int'(it.position) < eff_len())
          smp_mem[int'(it.in_channel) * MAX_IN_LEN + int'(it.position)] = it.sample_or_weight;
      default:
        due_outputs.push_back(conv_point(it.out_channel, it.position));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q   = 1;
      out_ch_q  = 1;
      taps_q    = 1;
      len_q     = 1;
      pad_q     = 0;
      dil_q     = 1;
      bias_en_q = 1'b0;
      due_outputs.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_output(out_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IN_CH:   in_ch_q   = cfg_data_i[NCH_W-1:0];
          REG_OUT_CH:  out_ch_q  = cfg_data_i[NCH_W-1:0];
          REG_TAPS:    taps_q    = cfg_data_i[NTAP_W-1:0];
          REG_IN_LEN:  len_q     = cfg_data_i[LEN_W-1:0];
          REG_PAD:     pad_q     = cfg_data_i[PAD_W-1:0];
          REG_DIL:     dil_q     = cfg_data_i[DIL_W-1:0];
          REG_BIAS_EN: bias_en_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) apply_item(in_item_i);
    end
    pending_o = due_outputs.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives the dilated 1-D convolution block through register settings, gives the verdict
`timescale 1ns / 1ps
module testbench;
  import dpc1d_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int WRITE_SETTLE = 4;
  localparam int QUERY_SETTLE = MAX_IN_CH * MAX_TAPS + 8;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int W_LOW     = -32768;
  localparam int W_HIGH    = 32767;
  localparam int BIAS_LOW  = 32'sh8000_0000;
  localparam int BIAS_HIGH = 32'sh7fff_ffff;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  int                    mismatches;
  int                    pending;

  int burst_left = 0;
  int stall_hold = 0;
  int sent_items = 0;
  int cur_nic = 1, cur_noc = 1, cur_nk = 1, cur_len = 1, cur_pad = 0, cur_dil = 1;
  bit wt_set   [W_DEPTH];
  bit smp_set  [S_DEPTH];
  bit bias_set [MAX_OUT_CH];

  dilated_padded_conv1d_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  conv_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .mismatch_o  (mismatches),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall_i <= 1'b0;
          stall_hold  <= $urandom_range(16, 160);
        end
        1: begin
          out_stall_i <= 1'b1;
          stall_hold  <= $urandom_range(1, 24);
        end
        default: begin
          out_stall_i <= 1'($urandom_range(0, 1));
          stall_hold  <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  function automatic int rand_q15();
    case ($urandom_range(0, 9))
      0:       return W_LOW;
      1:       return W_HIGH;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_bias();
    case ($urandom_range(0, 9))
      0:       return BIAS_LOW;
      1:       return BIAS_HIGH;
      default: return int'($urandom);
    endcase
  endfunction

  // size codes: the size itself or an out-of-range code the block must read as the nearest bound
  function automatic logic [CFG_DATA_W-1:0] size_code(input int eff, input int maxv,
                                                      input int w);
    if (eff == 1 && $urandom_range(0, 1) == 1) return '0;
    if (eff == maxv && $urandom_range(0, 1) == 1)
      return CFG_DATA_W'($urandom_range(maxv, (1 << w) - 1));
    return CFG_DATA_W'(eff);
  endfunction

  task automatic push_item(input mode_e m, input int oc, input int ic, input int tap,
                           input int pos, input int sw, input int bv);
    in_item_t it;
    int       gap;
    it.mode             = m;
    it.out_channel      = CH_W'(oc);
    it.in_channel       = CH_W'(ic);
    it.tap              = TAP_W'(tap);
    it.position         = POS_W'(pos);
    it.sample_or_weight = SAMPLE_W'(sw);
    it.bias_value       = BIAS_W'(bv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    sent_items++;
  endtask

  task automatic put_weight(input int oc, input int ic, input int tap, input int val);
    wt_set[(oc * MAX_IN_CH + ic) * MAX_TAPS + tap] = 1'b1;
    push_item(MODE_WEIGHT, oc, ic, tap, $urandom_range(0, 511), val, int'($urandom));
  endtask

  task automatic put_sample(input int ic, input int pos, input int val);
    if (pos < cur_len) smp_set[ic * MAX_IN_LEN + pos] = 1'b1;
    push_item(MODE_SAMPLE, $urandom_range(0, 15), ic, $urandom_range(0, 7), pos, val,
              int'($urandom));
  endtask

  task automatic put_bias(input int oc, input int val);
    bias_set[oc] = 1'b1;
    push_item(MODE_BIAS, oc, $urandom_range(0, 15), $urandom_range(0, 7),
              $urandom_range(0, 511), rand_q15(), val);
  endtask

  task automatic ask(input int oc, input int pos);
    push_item(MODE_QUERY, oc, $urandom_range(0, 15), $urandom_range(0, 7), pos, rand_q15(),
              int'($urandom));
  endtask

  task automatic drain_results(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_shape(input int nic, input int noc, input int nk, input int nlen,
                           input int pad, input int dil, input int ben);
    drain_results(WRITE_SETTLE);
    cur_nic = nic;
    cur_noc = noc;
    cur_nk  = nk;
    cur_len = nlen;
    cur_pad = pad;
    cur_dil = dil;
    write_reg(REG_IN_CH, size_code(nic, MAX_IN_CH, NCH_W));
    write_reg(REG_OUT_CH, size_code(noc, MAX_OUT_CH, NCH_W));
    write_reg(REG_TAPS, size_code(nk, MAX_TAPS, NTAP_W));
    write_reg(REG_IN_LEN, size_code(nlen, MAX_IN_LEN, LEN_W));
    write_reg(REG_PAD, CFG_DATA_W'(pad));
    write_reg(REG_DIL, size_code(dil, (1 << DIL_W) - 1, DIL_W));
    write_reg(REG_BIAS_EN, CFG_DATA_W'(ben));
    if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // every entry a query of this shape can read gets written, some get rewritten
  task automatic load_stores();
    int oc, ic, k, p;
    for (oc = 0; oc < cur_noc; oc++)
      for (ic = 0; ic < cur_nic; ic++)
        for (k = 0; k < cur_nk; k++)
          if (!wt_set[(oc * MAX_IN_CH + ic) * MAX_TAPS + k] || $urandom_range(0, 7) == 0)
            put_weight(oc, ic, k, rand_q15());
    for (ic = 0; ic < cur_nic; ic++)
      for (p = 0; p < cur_len; p++)
        if (!smp_set[ic * MAX_IN_LEN + p] || $urandom_range(0, 7) == 0)
          put_sample(ic, p, rand_q15());
    for (oc = 0; oc < cur_noc; oc++)
      if (!bias_set[oc] || $urandom_range(0, 3) == 0) put_bias(oc, rand_bias());
  endtask

  task automatic mix_items(input int count);
    int n, r, olen, oc, ic, pos;
    olen = cur_len + 2 * cur_pad - cur_dil * (cur_nk - 1);
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        oc  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, cur_noc - 1)
                                          : $urandom_range(0, 15);
        pos = (olen > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, olen - 1)
                                                      : $urandom_range(0, 511);
        ask(oc, pos);
      end else if (r < 68) begin
        ic  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_nic - 1)
                                          : $urandom_range(0, 15);
        pos = ($urandom_range(0, 6) != 0) ? $urandom_range(0, cur_len - 1)
                                          : $urandom_range(0, 511);
        put_sample(ic, pos, rand_q15());
      end else if (r < 90) begin
        if ($urandom_range(0, 4) != 0)
          put_weight($urandom_range(0, cur_noc - 1), $urandom_range(0, cur_nic - 1),
                     $urandom_range(0, cur_nk - 1), rand_q15());
        else
          put_weight($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                     rand_q15());
      end else begin
        put_bias($urandom_range(0, 15), rand_bias());
      end
    end
  endtask

  initial begin
    int nic, noc, nk, nlen, pad, dil, mix_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one channel, one tap, one sample
    put_weight(0, 0, 0, W_LOW);
    put_sample(0, 0, W_LOW);
    put_bias(0, BIAS_HIGH);
    ask(0, 0);
    put_sample(0, 1, 1234);
    put_sample(15, 511, W_HIGH);
    ask(0, 1);
    ask(15, 511);
    put_weight(15, 15, 7, W_HIGH);
    put_bias(15, BIAS_LOW);
    put_sample(15, 0, W_HIGH);
    put_weight(0, 0, 0, W_HIGH);
    ask(0, 0);
    ask(1, 0);
    set_shape(1, 1, 1, 1, 0, 1, 1);
    ask(0, 0);
    put_bias(0, BIAS_LOW);
    ask(0, 0);

    set_shape(MAX_IN_CH, 2, 3, 8, 1, 2, 1);
    load_stores();
    mix_items(40);
    set_shape(1, MAX_OUT_CH, 2, 12, 0, 1, 1);
    load_stores();
    mix_items(40);
    set_shape(1, 2, MAX_TAPS, MAX_IN_LEN, 127, 64, 0);
    load_stores();
    mix_items(60);
    // taps reach past the padded input: no output time exists
    set_shape(3, 3, MAX_TAPS, 20, 0, 64, 1);
    load_stores();
    mix_items(30);
    set_shape(1, 1, 1, 1, 0, 1, 0);
    load_stores();
    mix_items(20);

    while (sent_items < RANDOM_ITEMS) begin
      nic  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_IN_CH) : $urandom_range(1, 4);
      noc  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_OUT_CH) : $urandom_range(1, 4);
      nk   = $urandom_range(1, MAX_TAPS);
      nlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      pad  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
      dil  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 3);
      set_shape(nic, noc, nk, nlen, pad, dil, $urandom_range(0, 1));
      load_stores();
      mix_len = $urandom_range(60, 140);
      if (sent_items + mix_len > RANDOM_ITEMS)
        mix_len = (RANDOM_ITEMS > sent_items + 8) ? RANDOM_ITEMS - sent_items : 8;
      mix_items(mix_len);
    end

    drain_results(QUERY_SETTLE);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(36_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dpc1d_pkg.sv
hdl/dpc1d_cfg.sv
hdl/dpc1d_ctrl.sv
hdl/dpc1d_dp.sv
hdl/dilated_padded_conv1d_top.sv
bench/conv_checker.sv
bench/testbench.sv
